/* rtl/hps_pkg.sv */
// Package for the HTTP prefix skipper: status and phase codes, parser state
// type, match tables and sizing constants. No dependencies.
package hps_pkg;

   localparam int SEED_MESSAGE_BYTES = 24;
   localparam int POSITION_WIDTH     = 16;
   localparam int COMPAT_BYTES       = 16;
   localparam int METHOD_COUNT       = 8;
   localparam int METHOD_MAX_LEN     = 7;

   typedef enum logic [2:0] {
      ST_DECIDING  = 3'd0,
      ST_NO_PREFIX = 3'd1,
      ST_INSIDE    = 3'd2,
      ST_END       = 3'd3,
      ST_AFTER     = 3'd4
   } hps_status_type;

   typedef enum logic [1:0] {
      PH_DECIDE = 2'd0,
      PH_INSIDE = 2'd1,
      PH_DONE   = 2'd2
   } hps_phase_type;

   typedef struct packed {
      hps_phase_type              phase;
      logic [POSITION_WIDTH-1:0]  pos;
      logic [METHOD_COUNT-1:0]    cand;
      logic                       compat;
      logic                       scan;
      logic [1:0]                 prog;
   } hps_state_type;

   typedef struct packed {
      hps_status_type status;
      logic [4:0]     skip;
   } hps_result_type;

   localparam hps_state_type HPS_STATE_RESET = '{
      phase:  PH_DECIDE,
      pos:    '0,
      cand:   '1,
      compat: 1'b1,
      scan:   1'b0,
      prog:   2'd0
   };

   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_LF = 8'd10;

   // "GET / HTTP/1.0" CR LF
   localparam logic [7:0] COMPAT_LINE [COMPAT_BYTES] = '{
      8'h47, 8'h45, 8'h54, 8'h20, 8'h2F, 8'h20, 8'h48, 8'h54,
      8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h30, 8'd13, 8'd10
   };

   // OPTIONS GET HEAD POST PUT DELETE TRACE CONNECT, zero padded
   localparam logic [7:0] METHOD_TEXT [METHOD_COUNT][METHOD_MAX_LEN] = '{
      '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53},
      '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h48, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00},
      '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00},
      '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00},
      '{8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h00, 8'h00},
      '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54}
   };

   localparam logic [2:0] METHOD_SIZE [METHOD_COUNT] = '{
      3'd7, 3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7
   };

   // terminator is CR LF CR LF: even progress expects CR
   function automatic logic [7:0] term_byte(input logic [1:0] prog);
      return prog[0] ? CHAR_LF : CHAR_CR;
   endfunction

endpackage

/* rtl/hps_step.sv */
// Next-state and result logic of the prefix parser for one byte.
// Depends on hps_pkg.
module hps_step
   import hps_pkg::*;
(
   input  hps_state_type  state_cur,
   input  logic [7:0]     data_byte,
   input  logic           first_byte,
   output hps_state_type  state_nxt,
   output hps_result_type result
);

   hps_state_type             base;
   hps_state_type             nxt;
   logic [POSITION_WIDTH-1:0] pos;
   logic [2:0]                p3;
   logic                      term_hit;
   logic                      done_term;
   logic [4:0]                end_off;

   always_comb begin
      base      = first_byte ? HPS_STATE_RESET : state_cur;
      nxt       = base;
      pos       = base.pos;
      p3        = pos[2:0];
      term_hit  = (data_byte == term_byte(base.prog));
      done_term = 1'b0;
      result.status = ST_DECIDING;
      result.skip   = '0;
      if (32'(pos) >= 32'(SEED_MESSAGE_BYTES)) begin
         end_off = 5'(SEED_MESSAGE_BYTES);
      end else begin
         end_off = pos[4:0] + 5'd1;
      end

      unique case (base.phase)
         PH_DECIDE: begin
            if (base.compat && (32'(pos) < 32'(COMPAT_BYTES)) &&
                (data_byte != COMPAT_LINE[pos[3:0]])) begin
               nxt.compat = 1'b0;
            end
            if (base.scan) begin
               done_term = term_hit && (base.prog == 2'd3);
               nxt.prog  = (term_hit && (base.prog != 2'd3)) ? base.prog + 2'd1 : 2'd0;
            end else if (32'(pos) < 32'(METHOD_MAX_LEN)) begin
               for (int i = 0; i < METHOD_COUNT; i++) begin
                  if (base.cand[i]) begin
                     if ((p3 < METHOD_SIZE[i]) && (data_byte != METHOD_TEXT[i][p3])) begin
                        nxt.cand[i] = 1'b0;
                     end else if (({1'b0, p3} + 4'd1) == {1'b0, METHOD_SIZE[i]}) begin
                        nxt.scan = 1'b1;
                     end
                  end
               end
            end else begin
               nxt.cand = '0;
            end

            if (nxt.compat && (32'(pos) == 32'(COMPAT_BYTES - 1))) begin
               result.status = ST_NO_PREFIX;
               nxt.phase     = PH_DONE;
            end else if (!nxt.scan && (nxt.cand == '0)) begin
               result.status = ST_NO_PREFIX;
               nxt.phase     = PH_DONE;
            end else if (nxt.scan && !nxt.compat) begin
               if (done_term) begin
                  result.status = ST_END;
                  result.skip   = end_off;
                  nxt.phase     = PH_DONE;
               end else begin
                  result.status = ST_INSIDE;
                  nxt.phase     = PH_INSIDE;
               end
            end
         end
         PH_INSIDE: begin
            nxt.prog = (term_hit && (base.prog != 2'd3)) ? base.prog + 2'd1 : 2'd0;
            if (term_hit && (base.prog == 2'd3)) begin
               result.status = ST_END;
               result.skip   = end_off;
               nxt.phase     = PH_DONE;
            end else begin
               result.status = ST_INSIDE;
            end
         end
         PH_DONE: begin
            result.status = ST_AFTER;
         end
         default: begin
            result.status = ST_AFTER;
         end
      endcase

      if (pos != '1) begin
         nxt.pos = pos + 1'b1;
      end
      state_nxt = nxt;
   end

endmodule

/* rtl/http_prefix_skipper.sv */
// HTTP prefix skipper top level: input register, parser state register,
// result register. Depends on hps_pkg and hps_step.
//
// Usage: bytes of a connection enter on the req_ channel, one item per byte;
// req_first_byte marks the first byte of a new connection and restarts the
// parser. Every accepted byte gives exactly one item on the rsp_ channel,
// in order: rsp_status (deciding, no prefix, inside prefix, prefix ends
// here, after prefix) and rsp_skip_offset, nonzero only when the prefix
// ends, holding the prefix length capped at the seed message length.
// An accepted byte sits in the input register until the result register is
// free or being read; its result is then loaded into the result register,
// which raises rsp_valid.
// Throughput is one byte per cycle while the receiver does not stall, set
// by the single parser state register that each byte updates.
// When the receiver stalls, the result register holds and the input
// register fills; req_ready drops only when both are occupied, so a byte
// is taken even while a finished result waits.
// Reset empties both registers and puts the parser in its new-connection
// state, so the first byte after reset counts as position zero.
module http_prefix_skipper
   import hps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [4:0] rsp_skip_offset
);

   logic           s1_valid_ff;
   logic [7:0]     s1_byte_ff;
   logic           s1_first_ff;
   hps_state_type  ps_ff;
   hps_state_type  ps_in;
   hps_result_type res_in;
   logic           out_valid_ff;
   hps_result_type res_ff;
   logic           advance;

   hps_step u_step (
      .state_cur  (ps_ff),
      .data_byte  (s1_byte_ff),
      .first_byte (s1_first_ff),
      .state_nxt  (ps_in),
      .result     (res_in)
   );

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ps_ff        <= HPS_STATE_RESET;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            ps_ff        <= ps_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff  <= req_data_byte;
         s1_first_ff <= req_first_byte;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = res_ff.status;
   assign rsp_skip_offset = res_ff.skip;

   a_skip_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_END)) |-> (rsp_skip_offset == 5'd0))
      else $error("skip offset set without prefix end");

   a_end_skip_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_END)) |->
      ((rsp_skip_offset != 5'd0) && (32'(rsp_skip_offset) <= SEED_MESSAGE_BYTES)))
      else $error("prefix end offset out of range");

   a_done_gives_after: assert property (@(posedge clock) disable iff (reset)
      (advance && (ps_ff.phase == PH_DONE) && !s1_first_ff) |=>
      (rsp_valid && (rsp_status == ST_AFTER)))
      else $error("byte after decision not reported as after prefix");

   a_inside_keeps_scan: assert property (@(posedge clock) disable iff (reset)
      (ps_ff.phase == PH_INSIDE) |-> (ps_ff.scan && !ps_ff.compat))
      else $error("inside prefix without active scan");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for http_prefix_skipper: byte-level parser model,
// random connections, idle and back-pressure phases. Depends on hps_pkg.
module testbench
   import hps_pkg::*;
();

   typedef struct {
      hps_status_type status;
      logic [4:0]     skip;
   } byte_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_first_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [4:0] rsp_skip_offset;

   http_prefix_skipper uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_skip_offset (rsp_skip_offset)
   );

   always #6 clock = ~clock;

   // parser model state
   hps_phase_type             prs_phase;
   logic [POSITION_WIDTH-1:0] prs_pos;
   logic [METHOD_COUNT-1:0]   prs_cand;
   logic                      prs_compat;
   logic                      prs_scan;
   logic [1:0]                prs_prog;

   byte_result_type pending_byte_results[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_left = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int connections = 0;
   int seen_ends = 0;
   int seen_capped = 0;
   int seen_no_prefix = 0;
   int seen_inside = 0;
   int seen_after = 0;

   task automatic restart_parser_model();
      prs_phase  = PH_DECIDE;
      prs_pos    = '0;
      prs_cand   = '1;
      prs_compat = 1'b1;
      prs_scan   = 1'b0;
      prs_prog   = 2'd0;
   endtask

   // CR LF CR LF tracker; returns 1 on the byte that completes it
   function automatic bit advance_terminator(input logic [7:0] b);
      logic [7:0] want;
      bit         hit;
      want = prs_prog[0] ? 8'd10 : 8'd13;
      hit = 1'b0;
      if (b == want) begin
         if (prs_prog == 2'd3) begin
            prs_prog = 2'd0;
            hit = 1'b1;
         end else begin
            prs_prog = prs_prog + 2'd1;
         end
      end else begin
         prs_prog = 2'd0;
      end
      return hit;
   endfunction

   function automatic logic [4:0] capped_prefix_length();
      int n;
      n = int'(prs_pos) + 1;
      if (n > SEED_MESSAGE_BYTES)
         n = SEED_MESSAGE_BYTES;
      return n[4:0];
   endfunction

   task automatic predict_parser_result(input logic [7:0] b, input logic first);
      byte_result_type           r;
      logic [POSITION_WIDTH-1:0] pos;
      bit                        was_scanning;
      bit                        done_term;
      r.status = ST_DECIDING;
      r.skip = 5'd0;
      done_term = 1'b0;
      if (first)
         restart_parser_model();
      pos = prs_pos;
      case (prs_phase)
         PH_DECIDE: begin
            was_scanning = prs_scan;
            if (prs_compat && pos < COMPAT_BYTES && b != COMPAT_LINE[pos[3:0]])
               prs_compat = 1'b0;
            if (was_scanning) begin
               done_term = advance_terminator(b);
            end else if (pos < METHOD_MAX_LEN) begin
               for (int i = 0; i < METHOD_COUNT; i++) begin
                  if (prs_cand[i]) begin
                     if (pos < METHOD_SIZE[i] && b != METHOD_TEXT[i][pos[2:0]])
                        prs_cand[i] = 1'b0;
                     else if (pos + 1 == METHOD_SIZE[i])
                        prs_scan = 1'b1;
                  end
               end
            end else begin
               prs_cand = '0;
            end
            if (prs_compat && pos == COMPAT_BYTES - 1) begin
               r.status = ST_NO_PREFIX;
               prs_phase = PH_DONE;
            end else if (!prs_scan && prs_cand == '0) begin
               r.status = ST_NO_PREFIX;
               prs_phase = PH_DONE;
            end else if (prs_scan && !prs_compat) begin
               if (done_term) begin
                  r.status = ST_END;
                  r.skip = capped_prefix_length();
                  prs_phase = PH_DONE;
               end else begin
                  r.status = ST_INSIDE;
                  prs_phase = PH_INSIDE;
               end
            end
         end
         PH_INSIDE: begin
            if (advance_terminator(b)) begin
               r.status = ST_END;
               r.skip = capped_prefix_length();
               prs_phase = PH_DONE;
            end else begin
               r.status = ST_INSIDE;
            end
         end
         default: r.status = ST_AFTER;
      endcase
      if (prs_pos != '1)
         prs_pos = prs_pos + 1'b1;
      pending_byte_results.push_back(r);
   endtask

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready = 1'b0;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_ready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      byte_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_byte_results.size() == 0) begin
            $error("result with no byte outstanding: status %0d skip %0d",
                   rsp_status, rsp_skip_offset);
            error_count++;
         end else begin
            want = pending_byte_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_skip_offset !== want.skip) begin
               $error("rsp_skip_offset: expected %0d, got %0d", want.skip,
                      rsp_skip_offset);
               error_count++;
            end
            case (want.status)
               ST_END: begin
                  seen_ends++;
                  if (want.skip == SEED_MESSAGE_BYTES)
                     seen_capped++;
               end
               ST_NO_PREFIX: seen_no_prefix++;
               ST_INSIDE:    seen_inside++;
               ST_AFTER:     seen_after++;
               default: ;
            endcase
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic first);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_byte = b;
      req_first_byte = first;
      do
         @(posedge clock);
      while (!req_ready);
      predict_parser_result(b, first);
      bytes_sent++;
      if (first)
         connections++;
   endtask

   task automatic send_text(input string s, input logic first);
      for (int k = 0; k < s.len(); k++)
         send_byte(s[k], first && k == 0);
   endtask

   // sender goes quiet until every outstanding result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_byte_results.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] header_byte();
      int pick;
      pick = $urandom_range(11);
      if (pick < 2)
         return 8'd13;
      else if (pick < 4)
         return 8'd10;
      else if (pick == 4)
         return 8'($urandom_range(255));
      return 8'($urandom_range(32, 126));
   endfunction

   task automatic send_random_connection();
      logic [7:0] conn[$];
      string      tail;
      int         kind;
      int         m;
      int         n;
      bit         restart;
      kind = $urandom_range(99);
      if (kind < 65) begin
         // well-formed request: method, header text, terminator, trailing data
         m = $urandom_range(METHOD_COUNT - 1);
         for (int k = 0; k < METHOD_SIZE[m]; k++)
            conn.push_back(METHOD_TEXT[m][k]);
         if (m == 1 && $urandom_range(1)) begin
            tail = " / HTTP/1.";
            for (int k = 0; k < tail.len(); k++)
               conn.push_back(tail[k]);
         end
         n = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
         repeat (n) conn.push_back(header_byte());
         if ($urandom_range(3) == 0) begin
            conn.push_back(8'd13);
            conn.push_back(8'd10);
            conn.push_back(8'd13);
            conn.push_back(8'($urandom_range(32, 126)));
         end
         conn.push_back(8'd13);
         conn.push_back(8'd10);
         conn.push_back(8'd13);
         conn.push_back(8'd10);
         repeat ($urandom_range(0, 3)) conn.push_back(8'($urandom_range(255)));
      end else if (kind < 75) begin
         // legacy request line, sometimes with one byte damaged
         for (int k = 0; k < COMPAT_BYTES; k++)
            conn.push_back(COMPAT_LINE[k]);
         if ($urandom_range(1))
            conn[$urandom_range(COMPAT_BYTES - 1)] = 8'($urandom_range(255));
         repeat ($urandom_range(0, 2)) conn.push_back(8'($urandom_range(255)));
      end else if (kind < 90) begin
         // method, sometimes broken, and always an unfinished terminator
         m = $urandom_range(METHOD_COUNT - 1);
         for (int k = 0; k < METHOD_SIZE[m]; k++)
            conn.push_back(METHOD_TEXT[m][k]);
         if ($urandom_range(1))
            conn[$urandom_range(METHOD_SIZE[m] - 1)] = header_byte();
         repeat ($urandom_range(0, 6)) conn.push_back(header_byte());
         conn.push_back(8'd13);
         conn.push_back(8'd10);
         conn.push_back(8'd13);
      end else begin
         repeat ($urandom_range(1, 8)) conn.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(9) == 0)
         conn = conn[0:$urandom_range(conn.size() - 1)];
      // now and then the bytes just continue the previous connection
      restart = ($urandom_range(19) != 0);
      foreach (conn[k])
         send_byte(conn[k], restart && k == 0);
   endtask

   task automatic run_random_connections(input int idle_pct, input int stall_pct,
                                         input int count);
      int stop_at;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at)
         send_random_connection();
      wait_for_results();
   endtask

   task automatic test_directed();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      // parser starts fresh after reset even without a first-byte flag
      send_byte("Z", 1'b0);
      send_byte(8'h00, 1'b0);
      send_text("GET / HTTP/1.0\015\012", 1'b1);
      send_byte(8'hFF, 1'b1);
      send_text("PUT\015\012\015\012", 1'b1);
      wait_for_results();
   endtask

   task automatic test_no_idling();
      run_random_connections(0, 0, 100);
   endtask

   task automatic test_sender_gaps();
      run_random_connections(59, 0, 100);
   endtask

   task automatic test_receiver_stalls();
      run_random_connections(0, 59, 100);
   endtask

   task automatic test_both_idle();
      run_random_connections(17, 17, 100);
   endtask

   // receiver blocked for a long stretch while bytes keep coming
   task automatic test_long_hold_off();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off_left = 60;
      send_text("OPTIONS * HTTP/1.1\015\012Host: a\015\012\015\012tail", 1'b1);
      wait_for_results();
   endtask

   initial begin
      restart_parser_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_no_idling();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_long_hold_off();

      repeat (10) @(posedge clock);
      $display("Sent %0d bytes over %0d connections with idle and stall phases.",
               bytes_sent, connections);
      $display("Prefix ends %0d (%0d capped), no prefix %0d, inside %0d, after %0d.",
               seen_ends, seen_capped, seen_no_prefix, seen_inside, seen_after);
      if (error_count == 0 && pending_byte_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #(400_000 * 12);
      $display("FAILURE");
      $finish;
   end

endmodule

/* sim.f */
rtl/hps_pkg.sv
rtl/hps_step.sv
rtl/http_prefix_skipper.sv
tb/sv/testbench.sv
